>>> sv/lzss_stream_decompressor_unit_defines.svh
// assertion macros shared by the lzss decompressor rtl
`ifndef LZSS_STREAM_DECOMPRESSOR_UNIT_DEFINES_SVH
`define LZSS_STREAM_DECOMPRESSOR_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define LZSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define LZSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/lzss_pkg.sv
// types and constants of the lzss stream decompressor
package lzss_pkg;

  localparam int HIST_DEPTH = 8192;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int CNT_W      = 31;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;

  localparam logic [7:0]       TOK_SINGLE  = 8'h80;
  localparam logic [7:0]       TOK_RUN     = 8'h00;
  localparam logic [3:0]       MAX_LEN     = 4'd15;
  localparam logic [CNT_W-1:0] LIMIT_RESET = {CNT_W{1'b1}};

  // register index of output_limit
  localparam logic REG_OUTPUT_LIMIT = 1'b0;

  // end of stream status codes
  localparam logic [1:0] ES_OK       = 2'd0;
  localparam logic [1:0] ES_MISMATCH = 2'd1;
  localparam logic [1:0] ES_TRUNC    = 2'd2;
  localparam logic [1:0] ES_LIMIT    = 2'd3;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_TOKEN  = 3'd1,
    PH_SINGLE = 3'd2,
    PH_COUNT  = 3'd3,
    PH_RUN    = 3'd4,
    PH_CODEHI = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_COPY = 2'd1,
    ST_STAT = 2'd2
  } state_t;

endpackage

>>> sv/lzss_if.sv
// valid/ready channels of the lzss decompressor: compressed input and decoded output
interface lzss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface lzss_out_if;
  logic                        valid;
  logic                        ready;
  logic [7:0]                  out_byte;
  logic                        is_status;
  logic [1:0]                  end_status;
  logic [lzss_pkg::CNT_W-1:0]  produced_length;
  logic                        last_of_run;

  modport source (output valid, output out_byte, output is_status, output end_status,
                  output produced_length, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input is_status, input end_status,
                  input produced_length, input last_of_run, output ready);
endinterface

>>> sv/lzss_stream_decompressor_unit.sv
// lzss stream decompressor: token parser, history memory and output register
// output: a literal word shows on the output in the cycle after it is accepted; a match
//   passes its words through the history read register and the output register, one a
//   cycle while the output is free; a match code with len 1..15 holds the input until
//   its words are copied, set by the single read port of the history memory
// reset: rst_n synchronous, active low; clears control state, output_limit to 2^31-1
//   the history memory is not cleared: no clearing pass, reads are masked instead
`include "lzss_stream_decompressor_unit_defines.svh"

module lzss_stream_decompressor_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  lzss_in_if.sink                       in_ch,
  lzss_out_if.source                    out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [lzss_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [lzss_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [lzss_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  localparam int AW = lzss_pkg::HIST_AW;
  localparam int CW = lzss_pkg::CNT_W;

  // control and parse state
  lzss_pkg::state_t state_r, state_nxt;
  lzss_pkg::phase_t phase_r, phase_nxt;
  logic [31:0]   hdr_r, hdr_nxt;
  logic [1:0]    hdr_idx_r, hdr_idx_nxt;
  logic [8:0]    run_rem_r, run_rem_nxt;
  logic [7:0]    tok_lo_r, tok_lo_nxt;
  logic          err_r, err_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [3:0]    copy_rem_r, copy_rem_nxt;
  logic [AW-1:0] dist_r, dist_nxt;
  logic          last_pend_r, last_pend_nxt;
  logic [CW-1:0] limit_r;

  // output register
  logic          ov_r;
  logic [7:0]    ob_r;
  logic          ost_r;
  logic [1:0]    oes_r;
  logic [CW-1:0] olen_r;
  logic          olr_r;

  // history memory
  logic [7:0]    hist_mem [lzss_pkg::HIST_DEPTH];
  logic [7:0]    rd_data_r;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  logic          out_free;
  logic          in_acc;
  logic          can_store;
  logic          emit_req;
  logic          emit_do;
  logic [7:0]    emit_byte;
  logic          emit_lor;
  logic          stat_load;
  logic          copy_go;
  logic [AW-1:0] dist_in;
  logic          src_zero;
  logic [1:0]    stat_code;
  logic          cfg_hit;

  // output slot frees when empty or being taken this cycle
  assign out_free    = !ov_r || out_ch.ready;
  assign in_ch.ready = (state_r == lzss_pkg::ST_IDLE) && out_free;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // bytes beyond the limit are dropped and flagged
  assign can_store = cnt_r < limit_r;

  // match distance is offset + 15, at most 4110, always inside the history
  assign dist_in = AW'({in_ch.in_byte, tok_lo_r[7:4]}) + AW'(lzss_pkg::MAX_LEN);

  // a source before the first byte of this stream reads as zero, which also
  // keeps data left from an earlier stream out of view
  assign src_zero = CW'(dist_r) > cnt_r;

  always_comb begin
    priority if (err_r) begin
      stat_code = lzss_pkg::ES_LIMIT;
    end else if (phase_r != lzss_pkg::PH_TOKEN) begin
      stat_code = lzss_pkg::ES_TRUNC;
    end else if (hdr_r != {1'b0, cnt_r}) begin
      stat_code = lzss_pkg::ES_MISMATCH;
    end else begin
      stat_code = lzss_pkg::ES_OK;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    hdr_nxt       = hdr_r;
    hdr_idx_nxt   = hdr_idx_r;
    run_rem_nxt   = run_rem_r;
    tok_lo_nxt    = tok_lo_r;
    err_nxt       = err_r;
    cnt_nxt       = cnt_r;
    wp_nxt        = wp_r;
    copy_rem_nxt  = copy_rem_r;
    dist_nxt      = dist_r;
    last_pend_nxt = last_pend_r;
    emit_req      = 1'b0;
    emit_byte     = in_ch.in_byte;
    emit_lor      = !in_ch.in_last;
    stat_load     = 1'b0;
    copy_go       = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = wp_r - dist_in;

    unique case (state_r)
      lzss_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (phase_r)
            lzss_pkg::PH_HEADER: begin
              hdr_nxt     = hdr_r | (32'(in_ch.in_byte) << {hdr_idx_r, 3'b000});
              hdr_idx_nxt = hdr_idx_r + 2'd1;
              if (hdr_idx_r == 2'd3) begin
                phase_nxt = lzss_pkg::PH_TOKEN;
              end
            end
            lzss_pkg::PH_TOKEN: begin
              priority if (in_ch.in_byte == lzss_pkg::TOK_SINGLE) begin
                phase_nxt = lzss_pkg::PH_SINGLE;
              end else if (in_ch.in_byte == lzss_pkg::TOK_RUN) begin
                phase_nxt = lzss_pkg::PH_COUNT;
              end else begin
                tok_lo_nxt = in_ch.in_byte;
                phase_nxt  = lzss_pkg::PH_CODEHI;
              end
            end
            lzss_pkg::PH_SINGLE: begin
              emit_req  = 1'b1;
              phase_nxt = lzss_pkg::PH_TOKEN;
            end
            lzss_pkg::PH_COUNT: begin
              run_rem_nxt = {1'b0, in_ch.in_byte} + 9'd1;
              phase_nxt   = lzss_pkg::PH_RUN;
            end
            lzss_pkg::PH_RUN: begin
              emit_req = 1'b1;
              if (run_rem_r != 9'd0) begin
                run_rem_nxt = run_rem_r - 9'd1;
              end
              if (run_rem_r <= 9'd1) begin
                phase_nxt = lzss_pkg::PH_TOKEN;
              end
            end
            lzss_pkg::PH_CODEHI: begin
              phase_nxt = lzss_pkg::PH_TOKEN;
              // zero length codes emit nothing
              if (tok_lo_r[3:0] != 4'd0) begin
                copy_go       = 1'b1;
                copy_rem_nxt  = tok_lo_r[3:0];
                dist_nxt      = dist_in;
                last_pend_nxt = in_ch.in_last;
                rd_en         = 1'b1;
                state_nxt     = lzss_pkg::ST_COPY;
              end
            end
            default: begin
              phase_nxt = lzss_pkg::PH_TOKEN;
            end
          endcase
          if (in_ch.in_last && !copy_go) begin
            state_nxt = lzss_pkg::ST_STAT;
          end
        end
      end

      lzss_pkg::ST_COPY: begin
        // a dropped byte needs no output slot
        if (out_free || !can_store) begin
          emit_req  = 1'b1;
          emit_byte = src_zero ? 8'd0 : rd_data_r;
          emit_lor  = !last_pend_r && (copy_rem_r == 4'd1 || (cnt_r + CW'(1)) == limit_r);
          if (copy_rem_r == 4'd1) begin
            state_nxt = last_pend_r ? lzss_pkg::ST_STAT : lzss_pkg::ST_IDLE;
          end else begin
            copy_rem_nxt = copy_rem_r - 4'd1;
            rd_en        = 1'b1;
            // next source follows the write pointer; dist >= 15 keeps it off the write
            rd_addr      = (can_store ? wp_r + AW'(1) : wp_r) - dist_r;
          end
        end
      end

      lzss_pkg::ST_STAT: begin
        if (out_free) begin
          stat_load = 1'b1;
          state_nxt = lzss_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = lzss_pkg::ST_IDLE;
      end
    endcase

    emit_do = emit_req && can_store;
    if (emit_do) begin
      wp_nxt  = wp_r + AW'(1);
      cnt_nxt = cnt_r + CW'(1);
    end
    if (emit_req && !can_store) begin
      err_nxt = 1'b1;
    end

    // end of stream: back to the start of a new stream
    if (stat_load) begin
      phase_nxt     = lzss_pkg::PH_HEADER;
      hdr_nxt       = '0;
      hdr_idx_nxt   = '0;
      run_rem_nxt   = '0;
      tok_lo_nxt    = '0;
      err_nxt       = 1'b0;
      cnt_nxt       = '0;
      wp_nxt        = '0;
      copy_rem_nxt  = '0;
      last_pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lzss_pkg::ST_IDLE;
      phase_r     <= lzss_pkg::PH_HEADER;
      hdr_r       <= '0;
      hdr_idx_r   <= '0;
      run_rem_r   <= '0;
      tok_lo_r    <= '0;
      err_r       <= 1'b0;
      cnt_r       <= '0;
      wp_r        <= '0;
      copy_rem_r  <= '0;
      last_pend_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      hdr_r       <= hdr_nxt;
      hdr_idx_r   <= hdr_idx_nxt;
      run_rem_r   <= run_rem_nxt;
      tok_lo_r    <= tok_lo_nxt;
      err_r       <= err_nxt;
      cnt_r       <= cnt_nxt;
      wp_r        <= wp_nxt;
      copy_rem_r  <= copy_rem_nxt;
      last_pend_r <= last_pend_nxt;
    end
  end

  // match distance, only meaningful while copying
  always_ff @(posedge clk) begin
    dist_r <= dist_nxt;
  end

  // history: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (emit_do) begin
      hist_mem[wp_r] <= emit_byte;
    end
    if (rd_en) begin
      rd_data_r <= hist_mem[rd_addr];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (emit_do || stat_load) begin
      ov_r <= 1'b1;
    end else if (out_ch.ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat_load) begin
      ob_r   <= 8'd0;
      ost_r  <= 1'b1;
      oes_r  <= stat_code;
      olen_r <= cnt_r;
      olr_r  <= 1'b1;
    end else if (emit_do) begin
      ob_r   <= emit_byte;
      ost_r  <= 1'b0;
      oes_r  <= lzss_pkg::ES_OK;
      olen_r <= '0;
      olr_r  <= emit_lor;
    end
  end

  assign out_ch.valid           = ov_r;
  assign out_ch.out_byte        = ob_r;
  assign out_ch.is_status       = ost_r;
  assign out_ch.end_status      = oes_r;
  assign out_ch.produced_length = olen_r;
  assign out_ch.last_of_run     = olr_r;

  // configuration port; pready is tied high, so no access waits
  assign cfg_hit    = cfg_paddr[lzss_pkg::CFG_AW-1] == lzss_pkg::REG_OUTPUT_LIMIT;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= lzss_pkg::LIMIT_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_hit) begin
      limit_r <= cfg_pwdata[CW-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_hit) begin
      cfg_prdata = {{(lzss_pkg::CFG_DW-CW){1'b0}}, limit_r};
    end
  end

  `LZSS_ASSERT_NOW(a_status_ends_run, out_ch.valid && out_ch.is_status, out_ch.last_of_run, "status word without last_of_run")
  `LZSS_ASSERT_NOW(a_copy_len_nonzero, state_r == lzss_pkg::ST_COPY, copy_rem_r != 4'd0, "copy state with nothing left")
  `LZSS_ASSERT_NOW(a_no_rw_collision, emit_do && rd_en, rd_addr != wp_r, "history read hits the entry being written")
  `LZSS_ASSERT_NEXT(a_stream_cleared, stat_load, cnt_r == '0 && wp_r == '0 && phase_r == lzss_pkg::PH_HEADER, "stream state not cleared after status")

endmodule

>>> tb/tb_lzss_stream_decompressor_unit.sv
// self-checking testbench of the lzss stream decompressor: random streams, idling, limit checks
module tb_lzss_stream_decompressor_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // cycles without any accepted word before the run is declared hung; the longest
  // quiet stretch of a good run comes from the long receiver hold-off
  localparam int STUCK_LIMIT = 4000;
  localparam int HOLD_OFF    = 300;
  // worst match keeps the block busy copying 15 words after its code word
  localparam int SETTLE      = 24;

  // one compressed word on the input channel
  typedef struct packed {
    logic [7:0] cbyte;
    logic       last_flag;
  } comp_word_t;

  // one decoded word on the output channel
  typedef struct packed {
    logic [7:0]                 dbyte;
    logic                       stat;
    logic [1:0]                 stat_code;
    logic [lzss_pkg::CNT_W-1:0] plen;
    logic                       run_end;
  } dec_word_t;

  logic clk;
  logic rst_n;

  lzss_in_if  in_ch ();
  lzss_out_if out_ch ();

  logic                        cfg_psel;
  logic                        cfg_penable;
  logic                        cfg_pwrite;
  logic [lzss_pkg::CFG_AW-1:0] cfg_paddr;
  logic [lzss_pkg::CFG_DW-1:0] cfg_pwdata;
  logic [lzss_pkg::CFG_DW-1:0] cfg_prdata;
  logic                        cfg_pready;

  lzss_stream_decompressor_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // compressed words waiting to be sent, decoded words waiting to arrive
  comp_word_t comp_words[$];
  dec_word_t  decoded_words[$];

  int mismatches  = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int stuck_cycles = 0;
  int rx_hold_left = 0;
  logic rx_hold_req;

  // decoder image: history, stream state and the output limit
  logic [7:0]                   hist_mem [lzss_pkg::HIST_DEPTH];
  logic [lzss_pkg::HIST_AW-1:0] wpos;
  logic [lzss_pkg::CNT_W-1:0]   emitted;
  logic [31:0]                  hdr_len;
  int                           hdr_seen;
  lzss_pkg::phase_t             phase;
  int                           run_left;
  logic [7:0]                   code_lo;
  logic                         limit_hit;
  logic [lzss_pkg::CNT_W-1:0]   out_limit;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // per-stream state back to its start, history included
  function automatic void clear_stream();
    foreach (hist_mem[i]) hist_mem[i] = 8'h00;
    wpos      = '0;
    emitted   = '0;
    hdr_len   = '0;
    hdr_seen  = 0;
    phase     = lzss_pkg::PH_HEADER;
    run_left  = 0;
    code_lo   = 8'h00;
    limit_hit = 1'b0;
  endfunction

  // one decoded byte: dropped once the limit is reached, else stored and expected
  function automatic int put_byte(logic [7:0] b);
    if (emitted >= out_limit) begin
      limit_hit = 1'b1;
      return 0;
    end
    hist_mem[wpos] = b;
    wpos++;
    emitted++;
    decoded_words.push_back('{b, 1'b0, lzss_pkg::ES_OK, '0, 1'b0});
    return 1;
  endfunction

  // expected decoded words for one accepted compressed word
  function automatic void decode_word(logic [7:0] b, logic fin);
    int n_new;
    logic [15:0] code;
    logic [15:0] src_dist;
    logic [lzss_pkg::HIST_AW-1:0] rd_at;
    logic [1:0] st;
    n_new = 0;
    case (phase)
      lzss_pkg::PH_HEADER: begin
        // original length, little-endian
        hdr_len |= 32'(b) << (8 * hdr_seen);
        hdr_seen++;
        if (hdr_seen >= 4) phase = lzss_pkg::PH_TOKEN;
      end
      lzss_pkg::PH_TOKEN: begin
        if (b == lzss_pkg::TOK_SINGLE) phase = lzss_pkg::PH_SINGLE;
        else if (b == lzss_pkg::TOK_RUN) phase = lzss_pkg::PH_COUNT;
        else begin
          code_lo = b;
          phase   = lzss_pkg::PH_CODEHI;
        end
      end
      lzss_pkg::PH_SINGLE: begin
        n_new += put_byte(b);
        phase = lzss_pkg::PH_TOKEN;
      end
      lzss_pkg::PH_COUNT: begin
        run_left = int'(b) + 1;
        phase    = lzss_pkg::PH_RUN;
      end
      lzss_pkg::PH_RUN: begin
        n_new += put_byte(b);
        run_left--;
        if (run_left == 0) phase = lzss_pkg::PH_TOKEN;
      end
      lzss_pkg::PH_CODEHI: begin
        code = {b, code_lo};
        src_dist = {4'h0, code[15:4]} + 16'(lzss_pkg::MAX_LEN);
        // byte by byte, so a copy may overlap the bytes it is producing;
        // a source before the stream start reads as zero
        for (int i = 0; i < int'(code[3:0]); i++) begin
          rd_at = wpos - src_dist[lzss_pkg::HIST_AW-1:0];
          n_new += put_byte((src_dist > emitted) ? 8'h00 : hist_mem[rd_at]);
        end
        phase = lzss_pkg::PH_TOKEN;
      end
      default: phase = lzss_pkg::PH_TOKEN;
    endcase

    if (fin) begin
      // limit beats truncation beats length mismatch
      if (limit_hit) st = lzss_pkg::ES_LIMIT;
      else if (phase != lzss_pkg::PH_TOKEN) st = lzss_pkg::ES_TRUNC;
      else if (hdr_len != {1'b0, emitted}) st = lzss_pkg::ES_MISMATCH;
      else st = lzss_pkg::ES_OK;
      decoded_words.push_back('{8'h00, 1'b1, st, emitted, 1'b0});
      n_new++;
      clear_stream();
    end
    if (n_new > 0) decoded_words[decoded_words.size()-1].run_end = 1'b1;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got_v, logic [31:0] want_v);
    mismatches++;
    if (mismatches <= 200)
      $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got_v, want_v);
  endtask

  // driver: offers the next compressed word unless told to idle this cycle
  always @(posedge clk) begin
    comp_word_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      // a word handed over on this edge is decoded by the predictor right away
      if (in_ch.valid) decode_word(in_ch.in_byte, in_ch.in_last);
      if (comp_words.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        nxt = comp_words.pop_front();
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= nxt.cbyte;
        in_ch.in_last <= nxt.last_flag;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver hold-off, counted here and started by a one-cycle request
  always @(posedge clk) begin
    if (rx_hold_req) rx_hold_left <= HOLD_OFF;
    else if (rx_hold_left != 0) rx_hold_left <= rx_hold_left - 1;
  end

  // monitor: every decoded word is checked field by field against the oldest expectation
  always @(posedge clk) begin
    dec_word_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (decoded_words.size() == 0) begin
          flag_mismatch("word with nothing expected, out_byte", out_ch.out_byte, 32'h0);
        end else begin
          want = decoded_words.pop_front();
          if (out_ch.out_byte !== want.dbyte)
            flag_mismatch("out_byte", out_ch.out_byte, want.dbyte);
          if (out_ch.is_status !== want.stat)
            flag_mismatch("is_status", out_ch.is_status, want.stat);
          if (out_ch.end_status !== want.stat_code)
            flag_mismatch("end_status", out_ch.end_status, want.stat_code);
          if (out_ch.produced_length !== want.plen)
            flag_mismatch("produced_length", out_ch.produced_length, want.plen);
          if (out_ch.last_of_run !== want.run_end)
            flag_mismatch("last_of_run", out_ch.last_of_run, want.run_end);
        end
      end
      out_ch.ready <= (rx_hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // watchdog on cycles where neither side moves a word
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // a fixed stream, first byte in the top occupied byte lane, last flag on its final byte
  function automatic void push_bytes(logic [8*16-1:0] seq, int n);
    for (int i = n - 1; i >= 0; i--)
      comp_words.push_back('{seq[8*i +: 8], i == 0});
  endfunction

  // waits until every queued word is sent and every expected word is in, then the block gets time to settle
  task automatic wait_idle();
    while (comp_words.size() != 0 || in_ch.valid || decoded_words.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // setup then access phase; only called while the block is idle
  task automatic write_limit(logic [lzss_pkg::CNT_W-1:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= lzss_pkg::CFG_AW'(4 * lzss_pkg::REG_OUTPUT_LIMIT);
    cfg_pwdata  <= {1'b0, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    out_limit = val;
  endtask

  // random streams: mostly well formed with random tokens, some cut short,
  // some with a wrong header, some pure noise
  task automatic queue_batch(int target);
    comp_word_t seq[$];
    int unsigned decoded;
    logic [31:0] hdr;
    logic [7:0] lo;
    int queued, roll, n_tok, kind, n, len, off, cut;
    queued = 0;
    while (queued < target) begin
      seq.delete();
      decoded = 0;
      roll  = $urandom_range(99);
      n_tok = $urandom_range(1, 10);
      for (int t = 0; t < n_tok; t++) begin
        kind = (roll >= 90) ? 99 : $urandom_range(9);
        if (kind == 99) begin
          // noise: two arbitrary bytes per token slot
          seq.push_back('{8'($urandom), 1'b0});
          seq.push_back('{8'($urandom), 1'b0});
        end else if (kind < 3) begin
          seq.push_back('{lzss_pkg::TOK_SINGLE, 1'b0});
          seq.push_back('{8'($urandom), 1'b0});
          decoded++;
        end else if (kind < 5) begin
          // literal run, a long one now and then
          n = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(7);
          seq.push_back('{lzss_pkg::TOK_RUN, 1'b0});
          seq.push_back('{8'(n), 1'b0});
          repeat (n + 1) seq.push_back('{8'($urandom), 1'b0});
          decoded += n + 1;
        end else begin
          // match code: small offsets mostly, so copies hit real history
          len = $urandom_range(15);
          off = ($urandom_range(4) == 0) ? $urandom_range(4095) : $urandom_range(3);
          lo  = {off[3:0], len[3:0]};
          // a low byte that reads as a literal token is not a code
          if (lo == lzss_pkg::TOK_RUN || lo == lzss_pkg::TOK_SINGLE) lo[0] = 1'b1;
          seq.push_back('{lo, 1'b0});
          seq.push_back('{off[11:4], 1'b0});
          decoded += lo[3:0];
        end
      end
      hdr = (roll < 80) ? decoded : $urandom;
      seq.push_front('{hdr[31:24], 1'b0});
      seq.push_front('{hdr[23:16], 1'b0});
      seq.push_front('{hdr[15:8], 1'b0});
      seq.push_front('{hdr[7:0], 1'b0});
      if (roll >= 65 && roll < 80) begin
        cut = $urandom_range(seq.size() - 2);
        while (seq.size() > cut + 1) void'(seq.pop_back());
      end
      seq[seq.size()-1].last_flag = 1'b1;
      foreach (seq[i]) comp_words.push_back(seq[i]);
      queued += seq.size();
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    rx_hold_req   = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'h00;
    in_ch.in_last = 1'b0;
    out_ch.ready  = 1'b0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    clear_stream();
    out_limit = lzss_pkg::LIMIT_RESET;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // slow receiver first
    tx_idle_pct <= 31;
    rx_idle_pct <= 85;

    // literal 0x00 and 0xff, header matches: ok
    push_bytes({8'h02, 8'h00, 8'h00, 8'h00, 8'h80, 8'h00, 8'h80, 8'hFF}, 8);
    // all-ones header, run of two, full-length copy from before the stream start,
    // zero-length code, then the stream ends inside a single-literal token
    push_bytes({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h01, 8'hAA, 8'h55,
                8'h1F, 8'h00, 8'h10, 8'h00, 8'h80}, 13);
    // stream ends inside the header
    push_bytes({8'h05, 8'h00}, 2);
    queue_batch(90);
    wait_idle();

    // tight limit, slow sender
    write_limit(lzss_pkg::CNT_W'(20));
    tx_idle_pct <= 85;
    rx_idle_pct <= 31;
    queue_batch(90);
    wait_idle();

    // zero limit: every decoded byte is dropped
    write_limit('0);
    queue_batch(30);
    wait_idle();

    // widest limit, no idling; the receiver then holds off while the sender keeps
    // offering, so the block backs up into its input
    write_limit(lzss_pkg::LIMIT_RESET);
    tx_idle_pct <= 0;
    rx_idle_pct <= 0;
    queue_batch(110);
    @(posedge clk);
    rx_hold_req <= 1'b1;
    @(posedge clk);
    rx_hold_req <= 1'b0;
    wait_idle();

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
